[rtl/flag_stack_with_popcount_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the flag stack with popcount
// Shared property shapes, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FLAG_STACK_WITH_POPCOUNT_MACROS_SVH
`define FLAG_STACK_WITH_POPCOUNT_MACROS_SVH

// Same-cycle implication.
`define FSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg
// Types, sizes and codes shared by the flag stack with popcount.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

   localparam int CAPACITY   = 1024;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W      = $clog2(CAPACITY + 1);
   localparam int ARG_W      = 12;
   localparam int TYPE_W     = 2;
   localparam int COUNT_W    = 11;
   localparam int STATUS_W   = 2;
   localparam int CMP_W      = ((LEN_W > ARG_W) ? LEN_W : ARG_W) + 1;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_SET    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_CLR    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESIZE = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_COUNT  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INDEX  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;

   typedef struct packed {
      logic [TYPE_W-1:0]       req_type;
      logic signed [ARG_W-1:0] argument;
   } fsp_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  set_count;
      logic [STATUS_W-1:0] status;
   } fsp_rsp_type;

endpackage

`default_nettype wire

[rtl/fsp_ram.sv]
// ----------------------------------------------------------------------------
// fsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/flag_stack_with_popcount.sv]
// ----------------------------------------------------------------------------
// flag_stack_with_popcount
// Tail-only stack of one-bit flags with a running count of set flags.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_payload and raise start while busy is low; the transaction is
//   taken at that clock edge. Request kinds: set flag, clear flag, append or
//   remove tail entries (signed argument), report count.
//   Every transaction returns one response on rsp_payload, marked by a
//   one-cycle rsp_valid strobe: the count of set flags afterwards and a
//   status. The receiver cannot stall; it must take the strobe.
// Sequence after the accept edge:
//   report, append, rejected request: answered from the check state
//   set / clear: one flag-memory read, then write-back in the update state
//   remove m entries: one entry walked per cycle through the single
//   flag-memory port pair and the shared count adder, then a drain state
//   for the last read. busy stays high for the whole transaction; a new
//   start is taken in the cycle the response is shown.
// Reset:
//   Synchronous, active high. Length and count go to zero, then a clearing
//   sweep zeroes all CAPACITY (1024) flag-memory entries with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module flag_stack_with_popcount
   import fsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire fsp_req_type req_payload,
   output      logic        rsp_valid,
   output      fsp_rsp_type rsp_payload
);

   // sequencer states
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   fsp_req_type      req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fsp_rsp_type      rsp_ff, rsp_in;

   // flag memory ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_data;

   // range checks on the held request
   logic             arg_neg;
   logic [ARG_W-1:0] mag;
   logic [CMP_W-1:0] arg_ext, mag_ext, len_ext, room;
   logic             idx_bad, grow_bad, shrink_bad;

   // shared count adjust
   logic             up, down;
   logic             done;
   logic [STATUS_W-1:0] status_c;
   logic             want;

   fsp_ram #(
      .WIDTH (1),
      .DEPTH (CAPACITY)
   ) u_flags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      arg_neg    = req_ff.argument[ARG_W-1];
      mag        = ARG_W'(-req_ff.argument);
      arg_ext    = {{(CMP_W-ARG_W){1'b0}}, req_ff.argument};
      mag_ext    = {{(CMP_W-ARG_W){1'b0}}, mag};
      len_ext    = {{(CMP_W-LEN_W){1'b0}}, length_ff};
      room       = CMP_W'(CAPACITY) - len_ext;
      idx_bad    = arg_neg || (arg_ext >= len_ext);
      grow_bad   = arg_ext > room;
      shrink_bad = mag_ext > len_ext;
      want       = (req_ff.req_type == REQ_SET);
   end

   always_comb begin
      state_in  = state_ff;
      length_in = length_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      req_in    = req_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = 1'b0;
      rd_addr   = ptr_ff;
      up        = 1'b0;
      down      = 1'b0;
      done      = 1'b0;
      status_c  = ST_OK;

      case (state_ff)
         S_CLEAR: begin
            // sweep zeros through the flag memory
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST_IDX) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (req_ff.req_type)
               REQ_SET, REQ_CLR: begin
                  if (idx_bad) begin
                     status_c = ST_INDEX;
                     done     = 1'b1;
                  end else begin
                     // fetch the current flag, decide on write-back next cycle
                     rd_addr  = IDX_W'(req_ff.argument);
                     ptr_in   = IDX_W'(req_ff.argument);
                     state_in = S_UPDATE;
                  end
               end
               REQ_RESIZE: begin
                  if (!arg_neg) begin
                     // append: new entries are already zero
                     if (grow_bad) begin
                        status_c = ST_BOUNDS;
                     end else begin
                        length_in = length_ff + LEN_W'(arg_ext);
                     end
                     done = 1'b1;
                  end else if (shrink_bad) begin
                     status_c = ST_BOUNDS;
                     done     = 1'b1;
                  end else begin
                     count_in = LEN_W'(mag_ext);
                     state_in = S_WALK;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_UPDATE: begin
            if (rd_data != want) begin
               wr_en   = 1'b1;
               wr_data = want;
               up      = want;
               down    = !want;
            end
            done = 1'b1;
         end
         S_WALK: begin
            // drop the tail entry; its old value returns next cycle
            rd_addr   = IDX_W'(length_ff - 1'b1);
            wr_addr   = IDX_W'(length_ff - 1'b1);
            wr_en     = 1'b1;
            length_in = length_ff - 1'b1;
            count_in  = count_ff - 1'b1;
            pend_in   = 1'b1;
            down      = pend_ff & rd_data;
            if (count_ff == LEN_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // account for the last entry read
            down    = pend_ff & rd_data;
            pend_in = 1'b0;
            done    = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         state_in = S_IDLE;
      end

      total_in         = total_ff + LEN_W'(up) - LEN_W'(down);
      rsp_valid_in     = done;
      rsp_in.set_count = COUNT_W'(total_in);
      rsp_in.status    = status_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         length_ff    <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds need no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/fsp_checker.sv]
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks on the flag stack with popcount, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flag_stack_with_popcount_macros.svh"

module fsp_checker
   import fsp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire fsp_rsp_type rsp_payload
);

   logic accept;
   logic status_legal;

   assign accept       = start && !busy;
   assign status_legal = rsp_payload.status inside {ST_OK, ST_INDEX, ST_BOUNDS};

   `FSP_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy low after an accepted transaction")
   `FSP_ASSERT_NOW(a_rsp_when_free, rsp_valid, !busy, "response shown while still busy")
   `FSP_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "response strobe longer than one cycle")
   `FSP_ASSERT_NOW(a_status_code, rsp_valid, status_legal, "undefined status code")

endmodule

bind flag_stack_with_popcount fsp_checker u_fsp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: flag stack with popcount testbench
// Drives set, clear, resize and report transactions through the start/busy
// handshake and checks every response strobe against a local model of the
// flag store, its length and its running count of set flags.
// ----------------------------------------------------------------------------

module tb_top;
   import fsp_pkg::*;

   localparam int N_RANDOM    = 450;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SHOW_ERRORS = 10;

   // Model of the flag stack plus the queue of responses still owed.
   class flag_scoreboard;
      bit          flags [CAPACITY];
      int          depth_now;
      int          ones;
      int          peak_depth;
      int          errors;
      int          checked;
      int          status_seen [4];
      fsp_rsp_type owed_q [$];

      function void flag_error(string msg);
         errors++;
         if (errors <= SHOW_ERRORS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      // Apply one accepted transaction and queue the response it must give.
      function void note_request(fsp_req_type r);
         fsp_rsp_type want;
         int          k;
         bit          v;
         want.status = ST_OK;
         k = int'(r.argument);
         case (r.req_type)
            REQ_SET, REQ_CLR: begin
               if (k < 0 || k >= depth_now) begin
                  want.status = ST_INDEX;
               end else begin
                  v = (r.req_type == REQ_SET);
                  if (flags[k] != v) begin
                     ones = v ? ones + 1 : ones - 1;
                     flags[k] = v;
                  end
               end
            end
            REQ_RESIZE: begin
               if (k > 0) begin
                  if (k > CAPACITY - depth_now) want.status = ST_BOUNDS;
                  else depth_now += k;
               end else if (k < 0) begin
                  if (-k > depth_now) begin
                     want.status = ST_BOUNDS;
                  end else begin
                     // walk the removed entries from the tail
                     repeat (-k) begin
                        depth_now--;
                        if (flags[depth_now]) ones--;
                        flags[depth_now] = 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (depth_now > peak_depth) peak_depth = depth_now;
         want.set_count = COUNT_W'(ones);
         owed_q = {owed_q, want};
      endfunction

      // Compare one response strobe with the oldest owed response.
      function void check_result(fsp_rsp_type got);
         fsp_rsp_type want;
         checked++;
         status_seen[got.status]++;
         if (owed_q.size() == 0) begin
            flag_error($sformatf("response with nothing owed: count %0d status %0d",
                                 got.set_count, got.status));
            return;
         end
         want = owed_q.pop_front();
         if (got.set_count !== want.set_count) begin
            flag_error($sformatf("set_count expected %0d, got %0d",
                                 want.set_count, got.set_count));
         end
         if (got.status !== want.status) begin
            flag_error($sformatf("status expected %0d, got %0d",
                                 want.status, got.status));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   fsp_req_type req_payload;
   logic        rsp_valid;
   fsp_rsp_type rsp_payload;

   flag_scoreboard sb = new();
   int             kind_sent [4];
   int             cycle_count;

   flag_stack_with_popcount u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycle_count, sb.owed_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response monitor: the strobe lasts one cycle and cannot be held off,
   // so take it at every edge where it is high.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_payload);
      end
   end

   // Present one transaction and hold it until the block takes it. Call at a
   // rising edge; start stays high on return so a back-to-back transaction
   // needs no second assignment in the same step.
   task automatic issue(input fsp_req_type r);
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
      kind_sent[r.req_type]++;
   endtask

   task automatic send(input logic [TYPE_W-1:0] kind, input int k);
      fsp_req_type r;
      r.req_type = kind;
      r.argument = ARG_W'(k);
      issue(r);
   endtask

   // Drop start and stay idle for the requested gap.
   task automatic idle_gap(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop start and hold until every owed response has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   // Pick a random transaction. Most are well formed against the current
   // length so the stack actually grows, fills and empties; the rest are
   // arbitrary arguments that mostly land out of range.
   function automatic fsp_req_type pick_request();
      fsp_req_type r;
      int          roll;
      int          len;
      int          k;
      len  = sb.depth_now;
      roll = $urandom_range(99);
      if (roll < 40) begin
         r.req_type = $urandom_range(1) ? REQ_SET : REQ_CLR;
         if (len > 0 && $urandom_range(9) < 8) k = $urandom_range(len - 1);
         else k = int'($urandom_range(2048)) - 1024;
      end else if (roll < 88) begin
         r.req_type = REQ_RESIZE;
         roll = $urandom_range(99);
         if (roll < 45 && len < CAPACITY) begin
            k = $urandom_range(1, (CAPACITY - len < 64) ? CAPACITY - len : 64);
         end else if (roll < 85 && len > 0) begin
            k = -int'($urandom_range(1, (len < 32) ? len : 32));
         end else if (roll < 88) begin
            k = CAPACITY - len;                      // fill to capacity
         end else if (roll < 90) begin
            k = -len;                                // empty it: long walk
         end else begin
            k = int'($urandom_range(2048)) - 1024;
         end
      end else begin
         r.req_type = REQ_COUNT;
         k = int'($urandom_range(2048)) - 1024;      // argument is don't-care
      end
      r.argument = ARG_W'(k);
      return r;
   endfunction

   initial begin
      fsp_req_type r;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first transaction waits out the clearing sweep
      // through the handshake.
      send(REQ_COUNT, 0);          // report on an empty stack
      send(REQ_SET, 0);            // index past an empty stack
      send(REQ_RESIZE, 0);         // zero count does nothing
      send(REQ_RESIZE, -1);        // remove from empty
      send(REQ_RESIZE, 1024);      // fill in one go
      send(REQ_RESIZE, 1);         // append past capacity
      send(REQ_SET, 0);
      send(REQ_SET, 1023);
      send(REQ_SET, 512);
      send(REQ_SET, 512);          // already set: count holds
      send(REQ_CLR, 1);            // already clear: count holds
      send(REQ_SET, -1);           // negative index
      send(REQ_SET, 1024);         // index equal to length
      send(REQ_CLR, -1024);
      send(REQ_COUNT, -1);
      send(REQ_RESIZE, -1024);     // remove everything, walk clears flags
      send(REQ_RESIZE, 1024);
      send(REQ_SET, 1023);
      send(REQ_SET, 1022);
      send(REQ_RESIZE, -1);        // removed tail entry was set
      send(REQ_RESIZE, -1024);     // one more than the length
      send(REQ_RESIZE, -1023);
      send(REQ_RESIZE, 5);
      send(REQ_SET, 4);
      send(REQ_CLR, 4);
      drain();

      // Random part: idle about 30% of the time, except for a calm stretch
      // of back-to-back transactions, and drain fully once in the middle.
      for (int i = 0; i < N_RANDOM; i++) begin
         r = pick_request();
         issue(r);
         if (i == N_RANDOM / 2) begin
            drain();
         end else if (!(i >= 150 && i < 260) && $urandom_range(99) < 30) begin
            idle_gap($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 4));
         end
      end

      // Wind down: wait for the last responses, then let the clock run on quietly.
      drain();
      repeat (10) @(posedge clock);

      $display("Covered %0d set, %0d clear, %0d resize, %0d report transactions;",
               kind_sent[REQ_SET], kind_sent[REQ_CLR], kind_sent[REQ_RESIZE],
               kind_sent[REQ_COUNT]);
      $display("%0d responses (ok %0d, bad index %0d, out of bounds %0d), peak length %0d",
               sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_INDEX],
               sb.status_seen[ST_BOUNDS], sb.peak_depth);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches in total", sb.errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
